FILE: src/dtps_pkg.sv
// Package for the two-tap delay-line pitch shifter.
// Widths, payload types and register indexes shared by the files in src but dtps_ram.
// No dependencies.
`default_nettype none

package dtps_pkg;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned XF_W       = FRAC_W;
  localparam int unsigned MAX_DELAY  = 4096;
  localparam int unsigned ADDR_W     = $clog2(MAX_DELAY);
  localparam int unsigned LEN_W      = ADDR_W + 1;
  localparam int unsigned POS_W      = ADDR_W + FRAC_W;
  localparam int unsigned RAMP_W     = POS_W + 1;
  localparam int unsigned PITCH_W    = 19;
  localparam int unsigned WEIGHT_W   = XF_W + 1;
  localparam int unsigned QUO_W      = XF_W + 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = PITCH_W;
  localparam int unsigned XF_ONE     = 1 << XF_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [LEN_W-1:0]           len_t;
  typedef logic [POS_W-1:0]           pos_t;
  typedef logic [RAMP_W-1:0]          ramp_t;
  typedef logic signed [PITCH_W-1:0]  pitch_t;
  typedef logic [WEIGHT_W-1:0]        weight_t;
  typedef logic [QUO_W-1:0]           quo_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_LENGTH = 1'b0,
    CFG_PITCH_SHIFT  = 1'b1
  } cfg_idx_t;

  localparam len_t    MIN_LEN    = LEN_W'(4);
  localparam len_t    MAX_LEN    = LEN_W'(MAX_DELAY);
  localparam sample_t SAMPLE_MAX = sample_t'((1 << (SAMPLE_W - 1)) - 1);
  localparam sample_t SAMPLE_MIN = sample_t'(-(1 << (SAMPLE_W - 1)));

endpackage

`default_nettype wire

FILE: src/dtps_in_if.sv
// Input channel of the pitch shifter: valid/ready plus one audio sample.
// Depends on dtps_pkg.
`default_nettype none

interface dtps_in_if;
  logic              valid;
  logic              ready;
  dtps_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

FILE: src/dtps_out_if.sv
// Result channel of the pitch shifter: valid/ready plus one audio sample.
// Depends on dtps_pkg.
`default_nettype none

interface dtps_out_if;
  logic              valid;
  logic              ready;
  dtps_pkg::sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

FILE: src/dtps_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dtps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/dtps_div.sv
// Restoring divider for the crossfade: quotient floor(2 * distance / length),
// one quotient bit per cycle. Depends on dtps_pkg.
`default_nettype none

module dtps_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  dtps_pkg::ramp_t dividend,
  input  dtps_pkg::len_t  divisor,
  output logic            busy_r,
  output dtps_pkg::quo_t  quo_r
);

  localparam int unsigned CNT_W = $clog2(dtps_pkg::QUO_W);

  logic [CNT_W-1:0]              cnt_r;
  logic [dtps_pkg::LEN_W-1:0]    rem_r;
  logic [dtps_pkg::LEN_W:0]      trial;
  logic                          take;

  assign trial = {rem_r, quo_r[dtps_pkg::QUO_W-1]};
  assign take  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(dtps_pkg::QUO_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dtps_pkg::LEN_W'(dividend[dtps_pkg::RAMP_W-1:dtps_pkg::QUO_W-1]);
      quo_r <= {dividend[dtps_pkg::QUO_W-2:0], 1'b0};
    end else if (busy_r) begin
      rem_r <= take ? dtps_pkg::LEN_W'(trial - {1'b0, divisor})
                    : dtps_pkg::LEN_W'(trial);
      quo_r <= {quo_r[dtps_pkg::QUO_W-2:0], take};
    end
  end

endmodule

`default_nettype wire

FILE: src/dtps_lerp.sv
// Shared two-stage interpolator: a + floor(w * (b - a) / 2^FRAC_W), saturated.
// One multiplier, registered product, registered result. Depends on dtps_pkg.
`default_nettype none

module dtps_lerp (
  input  logic              clk,
  input  dtps_pkg::sample_t a,
  input  dtps_pkg::sample_t b,
  input  dtps_pkg::weight_t w,
  output dtps_pkg::sample_t q_r
);

  localparam int unsigned DIFF_W = dtps_pkg::SAMPLE_W + 1;
  localparam int unsigned PROD_W = DIFF_W + dtps_pkg::WEIGHT_W + 1;
  localparam int unsigned SUM_W  = dtps_pkg::SAMPLE_W + 4;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_r;
  dtps_pkg::sample_t        a_r;
  logic signed [SUM_W-1:0]  sum;

  assign diff = DIFF_W'(b) - DIFF_W'(a);
  assign sum  = SUM_W'(a_r) + SUM_W'(prod_r >>> dtps_pkg::FRAC_W);

  always_ff @(posedge clk) begin
    prod_r <= diff * $signed({1'b0, w});
    a_r    <= a;
    if (sum > SUM_W'(dtps_pkg::SAMPLE_MAX)) begin
      q_r <= dtps_pkg::SAMPLE_MAX;
    end else if (sum < SUM_W'(dtps_pkg::SAMPLE_MIN)) begin
      q_r <= dtps_pkg::SAMPLE_MIN;
    end else begin
      q_r <= dtps_pkg::sample_t'(sum);
    end
  end

endmodule

`default_nettype wire

FILE: src/dual_tap_delay_pitch_shifter.sv
// Top level of the two-tap delay-line pitch shifter: sequencer, delay store,
// divider and interpolator. Depends on dtps_pkg, dtps_in_if, dtps_out_if,
// dtps_ram, dtps_div and dtps_lerp.
//
//   channel  | dir | handshake              | payload
//   in_chan  | in  | valid/ready            | sample_in  [23:0] signed
//   out_chan | out | valid/ready            | sample_out [23:0] signed
//   cfg_*    | in  | cfg_we (no wait state) | cfg_idx [0], cfg_wdata [18:0]
//
// Items are handled one at a time: the sequencer steps from acceptance to a
// loaded output register, and the next item can be accepted in the cycle
// after; the 18-step crossfade divider sets the pace, the store reads and the
// shared interpolator run beside it.
// After reset the delay store is swept to zero, one entry a cycle, over all
// 4096 entries; no item is accepted until then, configuration writes are.
// A new item is accepted while a result still waits; a stalled output holds
// the sequencer in its last step until the result register frees up.
`default_nettype none

module dual_tap_delay_pitch_shifter (
  input  logic                              clk,
  input  logic                              rst_n,
  dtps_in_if.sink                           in_chan,
  dtps_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [dtps_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [dtps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_POS1, S_POS2, S_RD1, S_RD2, S_RD3, S_RD4,
    S_L1, S_L2, S_L3, S_L4, S_RW, S_DIV, S_XF, S_MIX, S_MW1, S_MW2, S_OUT
  } state_t;

  localparam int unsigned RT_W = dtps_pkg::RAMP_W + 2;
  localparam int unsigned RH_W = dtps_pkg::RAMP_W + 1;

  state_t                  state_r;
  dtps_pkg::addr_t         clr_cnt_r;
  logic                    clr_done_r;
  dtps_pkg::len_t          dly_len_r;
  dtps_pkg::pitch_t        pitch_r;
  dtps_pkg::len_t          len_r;
  dtps_pkg::addr_t         wp_r;
  dtps_pkg::ramp_t         ramp_r;
  dtps_pkg::pos_t          pos1_r;
  dtps_pkg::pos_t          pos2_r;
  logic                    wrap1_r;
  dtps_pkg::ramp_t         d_r;
  dtps_pkg::sample_t       a1_r, b1_r, a2_r, b2_r, o1_r, o2_r, mix_r;
  dtps_pkg::weight_t       x_r;
  logic signed [RT_W-1:0]  rtmp_r;
  logic                    out_valid_r;
  dtps_pkg::sample_t       out_data_r;

  logic                    acc;
  dtps_pkg::len_t          len_c;
  dtps_pkg::addr_t         len_m1_c, len_m1_r;
  dtps_pkg::addr_t         wp_eff;
  dtps_pkg::ramp_t         lenq_c, lenq_r, ramp_eff;
  dtps_pkg::pos_t          half_r, wq;
  logic [RH_W-1:0]         rh1;
  logic                    wrap1;
  dtps_pkg::ramp_t         rh2;
  dtps_pkg::addr_t         i1, im1, i2, im2;
  logic signed [RT_W-1:0]  lenq_s;

  logic                          ram_we;
  dtps_pkg::addr_t               ram_waddr, ram_raddr;
  logic [dtps_pkg::SAMPLE_W-1:0] ram_wdata, ram_rdata;

  dtps_pkg::sample_t lerp_a, lerp_b, lerp_q;
  dtps_pkg::weight_t lerp_w;

  logic              div_busy;
  dtps_pkg::quo_t    div_quo, fold_c, dbl_c;
  dtps_pkg::weight_t x_c;

  assign acc = in_chan.valid && in_chan.ready;
  assign in_chan.ready = clr_done_r && (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.sample_out = out_data_r;

  always_comb begin
    if (dly_len_r < dtps_pkg::MIN_LEN) begin
      len_c = dtps_pkg::MIN_LEN;
    end else if (dly_len_r > dtps_pkg::MAX_LEN) begin
      len_c = dtps_pkg::MAX_LEN;
    end else begin
      len_c = dly_len_r;
    end
  end

  assign len_m1_c = dtps_pkg::ADDR_W'(len_c - dtps_pkg::LEN_W'(1));
  assign len_m1_r = dtps_pkg::ADDR_W'(len_r - dtps_pkg::LEN_W'(1));
  assign wp_eff   = ({1'b0, wp_r} >= len_c) ? len_m1_c : wp_r;
  assign lenq_c   = {len_c, {dtps_pkg::FRAC_W{1'b0}}};
  assign lenq_r   = {len_r, {dtps_pkg::FRAC_W{1'b0}}};
  assign ramp_eff = (ramp_r > lenq_c) ? '0 : ramp_r;
  assign half_r   = {len_r, {(dtps_pkg::FRAC_W - 1){1'b0}}};
  assign lenq_s   = $signed({2'b00, lenq_r});

  assign wq    = {wp_r, {dtps_pkg::FRAC_W{1'b0}}};
  assign rh1   = RH_W'(wq) + RH_W'(ramp_r);
  assign wrap1 = rh1 >= RH_W'(lenq_r);
  assign rh2   = dtps_pkg::RAMP_W'(pos1_r) + dtps_pkg::RAMP_W'(half_r);

  assign i1  = pos1_r[dtps_pkg::POS_W-1:dtps_pkg::FRAC_W];
  assign i2  = pos2_r[dtps_pkg::POS_W-1:dtps_pkg::FRAC_W];
  assign im1 = (i1 == '0) ? len_m1_r : i1 - dtps_pkg::ADDR_W'(1);
  assign im2 = (i2 == '0) ? len_m1_r : i2 - dtps_pkg::ADDR_W'(1);

  assign ram_we    = !clr_done_r || acc;
  assign ram_waddr = clr_done_r ? wp_eff : clr_cnt_r;
  assign ram_wdata = clr_done_r ? in_chan.sample_in : '0;

  always_comb begin
    case (state_r)
      S_POS2:  ram_raddr = im1;
      S_RD1:   ram_raddr = i1;
      S_RD2:   ram_raddr = im2;
      S_RD3:   ram_raddr = i2;
      default: ram_raddr = i1;
    endcase
  end

  always_comb begin
    case (state_r)
      S_L2: begin
        lerp_a = a2_r;
        lerp_b = b2_r;
        lerp_w = {1'b0, pos2_r[dtps_pkg::FRAC_W-1:0]};
      end
      S_MIX: begin
        lerp_a = o2_r;
        lerp_b = o1_r;
        lerp_w = x_r;
      end
      default: begin
        lerp_a = a1_r;
        lerp_b = b1_r;
        lerp_w = {1'b0, pos1_r[dtps_pkg::FRAC_W-1:0]};
      end
    endcase
  end

  assign fold_c = (div_quo > dtps_pkg::QUO_W'(dtps_pkg::XF_ONE))
                ? dtps_pkg::QUO_W'(2 * dtps_pkg::XF_ONE) - div_quo : div_quo;
  assign dbl_c  = {fold_c[dtps_pkg::QUO_W-2:0], 1'b0};

  always_comb begin
    if (dbl_c < dtps_pkg::QUO_W'(dtps_pkg::XF_ONE / 2)) begin
      x_c = '0;
    end else if (dbl_c - dtps_pkg::QUO_W'(dtps_pkg::XF_ONE / 2)
                 > dtps_pkg::QUO_W'(dtps_pkg::XF_ONE)) begin
      x_c = dtps_pkg::WEIGHT_W'(dtps_pkg::XF_ONE);
    end else begin
      x_c = dtps_pkg::WEIGHT_W'(dbl_c - dtps_pkg::QUO_W'(dtps_pkg::XF_ONE / 2));
    end
  end

  dtps_ram #(
    .WIDTH (dtps_pkg::SAMPLE_W),
    .DEPTH (dtps_pkg::MAX_DELAY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dtps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_RD1),
    .dividend (d_r),
    .divisor  (len_r),
    .busy_r   (div_busy),
    .quo_r    (div_quo)
  );

  dtps_lerp u_lerp (
    .clk (clk),
    .a   (lerp_a),
    .b   (lerp_b),
    .w   (lerp_w),
    .q_r (lerp_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_cnt_r   <= '0;
      clr_done_r  <= 1'b0;
      dly_len_r   <= dtps_pkg::MAX_LEN;
      pitch_r     <= '0;
      len_r       <= dtps_pkg::MAX_LEN;
      wp_r        <= dtps_pkg::ADDR_W'(dtps_pkg::MAX_DELAY - 1);
      ramp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (!clr_done_r) begin
        clr_cnt_r <= clr_cnt_r + dtps_pkg::ADDR_W'(1);
        if (clr_cnt_r == dtps_pkg::ADDR_W'(dtps_pkg::MAX_DELAY - 1)) begin
          clr_done_r <= 1'b1;
        end
      end

      if (cfg_we) begin
        case (dtps_pkg::cfg_idx_t'(cfg_idx))
          dtps_pkg::CFG_DELAY_LENGTH: dly_len_r <= cfg_wdata[dtps_pkg::LEN_W-1:0];
          dtps_pkg::CFG_PITCH_SHIFT:  pitch_r   <= $signed(cfg_wdata[dtps_pkg::PITCH_W-1:0]);
          default: ;
        endcase
      end

      if (out_chan.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (acc) begin
            len_r   <= len_c;
            wp_r    <= wp_eff;
            ramp_r  <= ramp_eff;
            state_r <= S_POS1;
          end
        end
        S_POS1: begin
          pos1_r  <= wrap1 ? dtps_pkg::POS_W'(rh1 - RH_W'(lenq_r))
                           : dtps_pkg::POS_W'(rh1);
          wrap1_r <= wrap1;
          state_r <= S_POS2;
        end
        S_POS2: begin
          pos2_r  <= (rh2 >= lenq_r) ? dtps_pkg::POS_W'(rh2 - lenq_r)
                                     : dtps_pkg::POS_W'(rh2);
          d_r     <= wrap1_r ? lenq_r - ramp_r : ramp_r;
          state_r <= S_RD1;
        end
        S_RD1: begin
          a1_r    <= $signed(ram_rdata);
          state_r <= S_RD2;
        end
        S_RD2: begin
          b1_r    <= $signed(ram_rdata);
          state_r <= S_RD3;
        end
        S_RD3: begin
          a2_r    <= $signed(ram_rdata);
          state_r <= S_RD4;
        end
        S_RD4: begin
          b2_r    <= $signed(ram_rdata);
          state_r <= S_L1;
        end
        S_L1: state_r <= S_L2;
        S_L2: state_r <= S_L3;
        S_L3: begin
          o1_r    <= lerp_q;
          state_r <= S_L4;
        end
        S_L4: begin
          o2_r    <= lerp_q;
          rtmp_r  <= $signed({2'b00, ramp_r}) - RT_W'(pitch_r);
          state_r <= S_RW;
        end
        S_RW: begin
          if (rtmp_r < 0) begin
            rtmp_r <= rtmp_r + lenq_s;
          end else if (rtmp_r >= lenq_s) begin
            rtmp_r <= rtmp_r - lenq_s;
          end else begin
            ramp_r  <= dtps_pkg::RAMP_W'(rtmp_r);
            wp_r    <= (wp_r == '0) ? len_m1_r : wp_r - dtps_pkg::ADDR_W'(1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            state_r <= S_XF;
          end
        end
        S_XF: begin
          x_r     <= x_c;
          state_r <= S_MIX;
        end
        S_MIX: state_r <= S_MW1;
        S_MW1: state_r <= S_MW2;
        S_MW2: begin
          mix_r   <= lerp_q;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= mix_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, wp_r} < len_r)
    else $error("write position outside the delay length");

  a_ramp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (ramp_r <= lenq_r))
    else $error("ramp position beyond the delay length while idle");

  a_taps_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD1) |->
      (dtps_pkg::RAMP_W'(pos1_r) < lenq_r) && (dtps_pkg::RAMP_W'(pos2_r) < lenq_r))
    else $error("tap position not wrapped into the delay length");

  a_div_finished: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_XF) |-> !div_busy && $past(state_r == S_DIV))
    else $error("crossfade taken before the divider finished");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking bench for the two-tap delay-line pitch shifter.
// Predicts each output sample from its own delay store and crossfade math.
// Depends on dtps_pkg, dtps_in_if, dtps_out_if and dual_tap_delay_pitch_shifter.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [dtps_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [dtps_pkg::CFG_DATA_W-1:0] cfg_wdata;

  dtps_in_if in_ch ();
  dtps_out_if out_ch ();

  dual_tap_delay_pitch_shifter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the block state
  dtps_pkg::sample_t line_mem [dtps_pkg::MAX_DELAY];
  longint  wr_ptr;
  longint  ramp;
  logic [dtps_pkg::LEN_W-1:0] len_reg;
  dtps_pkg::pitch_t  pitch_reg;

  dtps_pkg::sample_t pending [$];
  dtps_pkg::sample_t expected_out [$];
  int unsigned n_issued;
  int unsigned n_checked;
  int unsigned errors;
  bit      calm;
  bit      hold_req;
  int      hold_left;
  dtps_pkg::sample_t want;

  always #5 clk = ~clk;

  function automatic longint interp_tap(longint pos, longint n);
    longint i, im, frac, a, b;
    i = pos >>> dtps_pkg::FRAC_W;
    frac = pos & ((longint'(1) << dtps_pkg::FRAC_W) - 1);
    if (i >= n) i = n - 1;
    im = (i == 0) ? n - 1 : i - 1;
    a = line_mem[im];
    b = line_mem[i];
    return a + ((frac * (b - a)) >>> dtps_pkg::FRAC_W);
  endfunction

  function automatic dtps_pkg::sample_t shift_sample(dtps_pkg::sample_t s);
    longint n, nq, half, wq, rh1, rh2, d, o1, o2, x, mix, r, one;
    one = dtps_pkg::XF_ONE;
    n = len_reg;
    if (n < 4) n = 4;
    if (n > dtps_pkg::MAX_DELAY) n = dtps_pkg::MAX_DELAY;
    nq = n << dtps_pkg::FRAC_W;
    half = n << (dtps_pkg::FRAC_W - 1);
    if (wr_ptr >= n) wr_ptr = n - 1;
    if (ramp < 0 || ramp > nq) ramp = 0;
    line_mem[wr_ptr] = s;
    wq = wr_ptr << dtps_pkg::FRAC_W;
    rh1 = wq + ramp;
    if (rh1 >= nq) rh1 = rh1 - nq;
    rh2 = rh1 + half;
    if (rh2 >= nq) rh2 = rh2 - nq;
    o1 = interp_tap(rh1, n);
    o2 = interp_tap(rh2, n);
    d = rh1 - wq;
    if (d < 0) d = -d;
    x = (d << dtps_pkg::XF_W) / half;
    if (x > one) x = 2 * one - x;
    x = 2 * x - one / 2;
    if (x < 0) x = 0;
    else if (x > one) x = one;
    wr_ptr = (wr_ptr == 0) ? n - 1 : wr_ptr - 1;
    r = (ramp - longint'(pitch_reg)) % nq;
    if (r < 0) r = r + nq;
    ramp = r;
    mix = (o1 * x + o2 * (one - x)) >>> dtps_pkg::XF_W;
    if (mix > longint'(dtps_pkg::SAMPLE_MAX)) mix = dtps_pkg::SAMPLE_MAX;
    if (mix < longint'(dtps_pkg::SAMPLE_MIN)) mix = dtps_pkg::SAMPLE_MIN;
    return dtps_pkg::sample_t'(mix);
  endfunction

  task automatic write_reg(dtps_pkg::cfg_idx_t idx, logic [dtps_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == dtps_pkg::CFG_DELAY_LENGTH) len_reg = val[dtps_pkg::LEN_W-1:0];
    else pitch_reg = dtps_pkg::pitch_t'(val);
  endtask

  task automatic queue_item(dtps_pkg::sample_t s);
    pending.push_back(s);
    n_issued++;
  endtask

  task automatic wait_idle();
    while (n_checked < n_issued) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) expected_out.push_back(shift_sample(in_ch.sample_in));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 12)) begin
          in_ch.valid <= 1'b1;
          in_ch.sample_in <= pending.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_checked++;
        if (expected_out.size() == 0) begin
          errors++;
          $display("%0t: unexpected sample_out %0d", $time, out_ch.sample_out);
        end else begin
          want = expected_out.pop_front();
          if (want !== out_ch.sample_out) begin
            errors++;
            $display("%0t: sample_out expected %0d actual %0d", $time, want,
                     out_ch.sample_out);
          end
        end
      end
      if (hold_req) begin
        hold_left = 300;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || $urandom_range(0, 99) >= 12;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned k, cnt, phase, len;
    int pitch;
    dtps_pkg::sample_t s;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = dtps_pkg::CFG_DELAY_LENGTH;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    out_ch.ready = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    n_issued = 0;
    n_checked = 0;
    errors = 0;
    phase = 0;
    foreach (line_mem[i]) line_mem[i] = '0;
    len_reg = dtps_pkg::MAX_LEN;
    pitch_reg = '0;
    ramp = 0;
    wr_ptr = dtps_pkg::MAX_DELAY - 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, full-scale samples
    queue_item(dtps_pkg::SAMPLE_MAX);
    queue_item(dtps_pkg::SAMPLE_MIN);
    queue_item('0);
    queue_item(-1);
    wait_idle();

    // length below the minimum, fastest upward shift
    write_reg(dtps_pkg::CFG_DELAY_LENGTH, '0);
    write_reg(dtps_pkg::CFG_PITCH_SHIFT, dtps_pkg::CFG_DATA_W'(196608));
    queue_item(dtps_pkg::SAMPLE_MAX);
    queue_item(dtps_pkg::SAMPLE_MIN);
    queue_item(dtps_pkg::sample_t'(24'h555555));
    queue_item(dtps_pkg::sample_t'(24'hAAAAAA));
    queue_item(1);
    queue_item(-1);
    queue_item(dtps_pkg::SAMPLE_MAX);
    queue_item(dtps_pkg::SAMPLE_MIN);
    wait_idle();

    // fastest downward shift on a short line
    write_reg(dtps_pkg::CFG_PITCH_SHIFT, dtps_pkg::CFG_DATA_W'(-49152));
    write_reg(dtps_pkg::CFG_DELAY_LENGTH, dtps_pkg::CFG_DATA_W'(5));
    queue_item(dtps_pkg::SAMPLE_MIN);
    queue_item(dtps_pkg::SAMPLE_MAX);
    queue_item(dtps_pkg::sample_t'(24'h7F0000));
    queue_item(dtps_pkg::sample_t'(24'h80FFFF));
    queue_item('0);
    queue_item(dtps_pkg::sample_t'(24'h123456));
    wait_idle();

    // length above the maximum, pitch at the ends of the field
    write_reg(dtps_pkg::CFG_DELAY_LENGTH, dtps_pkg::CFG_DATA_W'(8191));
    write_reg(dtps_pkg::CFG_PITCH_SHIFT, dtps_pkg::CFG_DATA_W'(262143));
    queue_item(dtps_pkg::SAMPLE_MAX);
    queue_item(dtps_pkg::SAMPLE_MIN);
    wait_idle();
    write_reg(dtps_pkg::CFG_PITCH_SHIFT, dtps_pkg::CFG_DATA_W'(-262144));
    queue_item(dtps_pkg::sample_t'(24'h555555));
    queue_item(dtps_pkg::sample_t'(24'hAAAAAA));
    wait_idle();

    while (n_issued < 1420) begin
      wait_idle();
      k = $urandom_range(0, 9);
      if (k < 6) len = $urandom_range(4, 48);
      else if (k < 8) len = $urandom_range(49, dtps_pkg::MAX_DELAY);
      else len = $urandom_range(0, 8191);
      if (phase == 0 || $urandom_range(0, 2) != 0)
        write_reg(dtps_pkg::CFG_DELAY_LENGTH, dtps_pkg::CFG_DATA_W'(len));
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 4) == 0) pitch = $urandom_range(0, 524287);
        else pitch = int'($urandom_range(0, 245760)) - 49152;
        write_reg(dtps_pkg::CFG_PITCH_SHIFT, dtps_pkg::CFG_DATA_W'(pitch));
      end
      calm = ($urandom_range(0, 4) == 0);
      if (phase == 2 || phase == 9) hold_req = 1'b1;
      cnt = $urandom_range(30, 120);
      repeat (cnt) begin
        k = $urandom_range(0, 99);
        if (k < 8) s = dtps_pkg::SAMPLE_MAX;
        else if (k < 16) s = dtps_pkg::SAMPLE_MIN;
        else if (k < 30) s = dtps_pkg::sample_t'(int'($urandom_range(0, 511)) - 256);
        else s = dtps_pkg::sample_t'($urandom);
        queue_item(s);
      end
      phase++;
    end

    wait_idle();
    repeat (64) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
